[rtl/core/decimal_long_divider_unit_macros.svh]
// Assertion macros shared by the decimal long divider RTL.
`ifndef DECIMAL_LONG_DIVIDER_UNIT_MACROS_SVH
`define DECIMAL_LONG_DIVIDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dld_pkg.sv]
// Types, constants and helpers shared by the decimal long divider.
`timescale 1ns / 1ps
package dld_pkg;

  localparam int unsigned DataWidth   = 31;
  localparam int unsigned MaxDigits   = 10;
  localparam int unsigned PlacesWidth = 4;
  localparam int unsigned CntWidth    = $clog2(DataWidth);
  localparam int unsigned ProdWidth   = DataWidth + 4;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned DigitCntW   = 2;

  localparam logic [PlacesWidth-1:0] PlacesReset = PlacesWidth'(5);
  localparam logic [PlacesWidth-1:0] PlacesMax   = PlacesWidth'(MaxDigits);

  localparam logic KindQuot  = 1'b0;
  localparam logic KindDigit = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StEmitQuot,
    StDigit,
    StEmitDigit
  } dld_state_e;

  typedef struct packed {
    logic idle;
    logic load;
    logic div_step;
    logic quot_emit;
    logic digit_step;
    logic digit_emit;
  } dld_cmd_t;

  typedef struct packed {
    logic div_done;
    logic digit_done;
    logic quot_last;
    logic digit_last;
    logic out_free;
  } dld_status_t;

  // 10 * r as (r << 3) + (r << 1); fits since r < 2^DataWidth.
  function automatic logic [ProdWidth-1:0] mul10(input logic [DataWidth-1:0] r);
    logic [ProdWidth-1:0] w;
    w = ProdWidth'(r);
    return (w << 3) + (w << 1);
  endfunction

endpackage

[rtl/core/dld_datapath.sv]
// Datapath: restoring divider, digit extractor, places counter, output register.
`timescale 1ns / 1ps
module dld_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dld_pkg::dld_cmd_t               cmd_i,
  output dld_pkg::dld_status_t            status_o,
  input  logic [dld_pkg::DataWidth-1:0]   dividend_i,
  input  logic [dld_pkg::DataWidth-1:0]   divisor_value_i,
  input  logic                            cfg_valid_i,
  input  logic [dld_pkg::PlacesWidth-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic [dld_pkg::DataWidth-1:0]   result_value_o,
  output logic                            last_of_run_o
);
  import dld_pkg::*;

  logic [PlacesWidth-1:0] places_q, places_d;
  logic [DataWidth-1:0]   rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [ProdWidth-1:0]   t_q, t_d;
  logic [DigitCntW-1:0]   dcnt_q, dcnt_d;
  logic [DigitWidth-1:0]  digit_q, digit_d;
  logic [PlacesWidth-1:0] left_q, left_d;
  logic                   out_valid_q, out_valid_d;
  logic                   kind_q, kind_d, last_q, last_d;
  logic [DataWidth-1:0]   value_q, value_d;

  logic [DataWidth:0]     trial, trial_diff;
  logic                   trial_ge;
  logic [ProdWidth-1:0]   sub, t_diff;
  logic                   t_ge;

  // one restoring division step
  assign trial      = {rem_q, quo_q[DataWidth-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign trial_ge   = trial >= {1'b0, den_q};

  // one digit bit: compare against divisor scaled by 8, 4, 2, 1
  assign sub    = ProdWidth'(den_q) << dcnt_q;
  assign t_diff = t_q - sub;
  assign t_ge   = t_q >= sub;

  assign status_o.div_done   = (cnt_q == '0);
  assign status_o.digit_done = (dcnt_q == '0);
  assign status_o.quot_last  = (den_q == '0) || (rem_q == '0) || (left_q == '0);
  assign status_o.digit_last = (t_q == '0) || (left_q == PlacesWidth'(1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    places_d    = places_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    dcnt_d      = dcnt_q;
    digit_d     = digit_q;
    left_d      = left_q;
    kind_d      = kind_q;
    value_d     = value_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i && cmd_i.idle) begin
      places_d = cfg_data_i;
    end
    if (cmd_i.load) begin
      quo_d  = dividend_i;
      den_d  = divisor_value_i;
      rem_d  = '0;
      cnt_d  = CntWidth'(DataWidth - 1);
      left_d = (places_q > PlacesMax) ? PlacesMax : places_q;
    end
    if (cmd_i.div_step) begin
      rem_d = trial_ge ? trial_diff[DataWidth-1:0] : trial[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], trial_ge};
      cnt_d = cnt_q - CntWidth'(1);
    end
    if (cmd_i.quot_emit) begin
      out_valid_d = 1'b1;
      kind_d      = KindQuot;
      value_d     = (den_q == '0) ? '1 : quo_q;
      last_d      = status_o.quot_last;
      t_d         = mul10(rem_q);
      dcnt_d      = '1;
      digit_d     = '0;
    end
    if (cmd_i.digit_step) begin
      t_d     = t_ge ? t_diff : t_q;
      digit_d = {digit_q[DigitWidth-2:0], t_ge};
      dcnt_d  = dcnt_q - DigitCntW'(1);
    end
    if (cmd_i.digit_emit) begin
      out_valid_d = 1'b1;
      kind_d      = KindDigit;
      value_d     = DataWidth'(digit_q);
      last_d      = status_o.digit_last;
      left_d      = left_q - PlacesWidth'(1);
      t_d         = mul10(t_q[DataWidth-1:0]);
      dcnt_d      = '1;
      digit_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      places_q    <= PlacesReset;
      out_valid_q <= 1'b0;
    end else begin
      places_q    <= places_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    den_q   <= den_d;
    cnt_q   <= cnt_d;
    t_q     <= t_d;
    dcnt_q  <= dcnt_d;
    digit_q <= digit_d;
    left_q  <= left_d;
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_value_o = value_q;
  assign last_of_run_o  = last_q;

endmodule

[rtl/core/dld_ctrl.sv]
// Controller state machine sequencing the divider datapath.
`timescale 1ns / 1ps
module dld_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  dld_pkg::dld_status_t status_i,
  output dld_pkg::dld_cmd_t    cmd_o
);
  import dld_pkg::*;

  dld_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDivide;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = StEmitQuot;
        end
      end
      StEmitQuot: begin
        if (status_i.out_free) begin
          cmd_o.quot_emit = 1'b1;
          state_d = status_i.quot_last ? StIdle : StDigit;
        end
      end
      StDigit: begin
        cmd_o.digit_step = 1'b1;
        if (status_i.digit_done) begin
          state_d = StEmitDigit;
        end
      end
      StEmitDigit: begin
        if (status_i.out_free) begin
          cmd_o.digit_emit = 1'b1;
          state_d = status_i.digit_last ? StIdle : StDigit;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

[rtl/core/decimal_long_divider_unit.sv]
// Top level of the decimal long divider: controller plus datapath.
`timescale 1ns / 1ps
// Decimal long division, one division per input item.
// Input channel: in_valid_i / in_stall_o with dividend_i and divisor_value_i.
//   An item is taken when valid is high and stall is low; stall is high for
//   the whole run of a division, so one division is in flight at a time.
// Output channel: out_valid_o / out_stall_i. Each division yields the integer
//   quotient (result_kind_o = 0) and then up to decimal_places fractional
//   digits (result_kind_o = 1), one item each; last_of_run_o flags the final.
//   A zero divisor yields a single all-ones quotient.
// Config channel: cfg_valid_i / cfg_ready_o / cfg_data_i writes the places
//   count (values above 10 act as 10); ready is high only while idle.
// Sequence: the quotient comes from a bit-serial restoring divider and is
//   registered on the output once the division completes. Each digit takes
//   one compare/subtract step per digit bit, then an emit step; the
//   controller returns to idle as the last result is loaded, and the next
//   item may then be taken.
// Stall: the output register holds while out_stall_i is high and the
//   controller waits in its emit state; nothing is dropped.
// Reset: returns to idle, clears the output valid, places count back to 5.
`include "decimal_long_divider_unit_macros.svh"
module decimal_long_divider_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dld_pkg::DataWidth-1:0]   dividend_i,
  input  logic [dld_pkg::DataWidth-1:0]   divisor_value_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dld_pkg::PlacesWidth-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic [dld_pkg::DataWidth-1:0]   result_value_o,
  output logic                            last_of_run_o
);
  import dld_pkg::*;

  dld_cmd_t    cmd;
  dld_status_t status;

  // controller sees only in_valid_i and status flags; all arithmetic lives in the datapath
  dld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dld_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .dividend_i      (dividend_i),
    .divisor_value_i (divisor_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .result_value_o  (result_value_o),
    .last_of_run_o   (last_of_run_o)
  );

  // accept only in idle; config only while idle
  assign in_stall_o  = !cmd.idle;
  assign cfg_ready_o = cmd.idle;

  `DLD_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted item did not start a run")
  `DLD_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.quot_emit || cmd.digit_emit, !out_valid_o || !out_stall_i, "pending result overwritten")
  `DLD_ASSERT_IMPL(a_digit_range, clk_i, rst_ni, out_valid_o && (result_kind_o == KindDigit), result_value_o <= DataWidth'(9), "fraction digit above nine")

endmodule
